// ----- design/bmalloc_pkg.sv -----
`timescale 1ns / 1ps

package bmalloc_pkg;

   localparam int DEF_BLOCK_BYTES     = 4096;
   localparam int DEF_MAX_FILE_BLOCKS = 12;

   localparam int MAP_WORD_BITS = 32;
   localparam int MAP_WORDS     = 1024;
   localparam int WIDX_W        = $clog2(MAP_WORDS);
   localparam int BIT_W         = $clog2(MAP_WORD_BITS);
   localparam int ENTRY_W       = WIDX_W + BIT_W;
   localparam int MAP_ENTRIES   = MAP_WORDS * MAP_WORD_BITS;
   localparam int LIMIT_W       = 16;
   localparam int CSR_W         = 2;

   typedef logic [MAP_WORD_BITS-1:0] word_type;

   // Operation codes.
   localparam logic [2:0] OP_LOAD_INODE = 3'd0;
   localparam logic [2:0] OP_LOAD_DATA  = 3'd1;
   localparam logic [2:0] OP_READ_INODE = 3'd2;
   localparam logic [2:0] OP_READ_DATA  = 3'd3;
   localparam logic [2:0] OP_ALLOC      = 3'd4;

   // Result status codes.
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_TOO_LARGE = 3'd1;
   localparam logic [2:0] ST_NO_INODE  = 3'd2;
   localparam logic [2:0] ST_NO_BLOCKS = 3'd3;
   localparam logic [2:0] ST_OVERFLOW  = 3'd4;

   // Configuration register indexes.
   localparam logic [CSR_W-1:0] CSR_INODE_TOTAL = 2'd0;
   localparam logic [CSR_W-1:0] CSR_DATA_TOTAL  = 2'd1;
   localparam logic [CSR_W-1:0] CSR_DATA_BASE   = 2'd2;

   // Map read address sources.
   localparam logic [1:0] RS_REQ    = 2'd0;
   localparam logic [1:0] RS_SCAN   = 2'd1;
   localparam logic [1:0] RS_INODE  = 2'd2;
   localparam logic [1:0] RS_CHOSEN = 2'd3;

   // Map write kinds.
   localparam logic [1:0] WR_NONE  = 2'd0;
   localparam logic [1:0] WR_LOAD  = 2'd1;
   localparam logic [1:0] WR_IMARK = 2'd2;
   localparam logic [1:0] WR_BMARK = 2'd3;

   // Result kinds.
   localparam logic [1:0] EMIT_NONE  = 2'd0;
   localparam logic [1:0] EMIT_READ  = 2'd1;
   localparam logic [1:0] EMIT_ERR   = 2'd2;
   localparam logic [1:0] EMIT_BLOCK = 2'd3;

   typedef struct packed {
      logic [2:0]  operation;
      logic [9:0]  word_index;
      logic [31:0] word_value;
      logic [31:0] file_size_bytes;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [15:0] inode_number;
      logic [31:0] block_number;
      logic [3:0]  block_slot;
      logic [31:0] read_value;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic       capture;
      logic       scan_init;
      logic       scan_next;
      logic       ino_take;
      logic       bword_load;
      logic       pick;
      logic       slot_next;
      logic [1:0] rd_sel;
      logic [1:0] map_wr;
      logic [1:0] emit;
      logic [2:0] err;
   } cmd_type;

   typedef struct packed {
      logic [2:0] op;
      logic       too_large;
      logic       inode_none;
      logic       ino_found;
      logic       ino_last;
      logic       dlimit_zero;
      logic       bfree_nz;
      logic       blk_last;
      logic       pick_done;
      logic       ovf;
      logic       slot_last;
   } stat_type;

   // Index of the lowest set bit; zero when none is set.
   function automatic logic [BIT_W-1:0] lowest_one(input word_type w);
      logic [BIT_W-1:0] r;
      r = '0;
      for (int i = MAP_WORD_BITS - 1; i >= 0; i--) begin
         if (w[i]) begin
            r = BIT_W'(i);
         end
      end
      return r;
   endfunction

   // Ones in the positions below rem, all ones when rem covers the word.
   function automatic word_type low_mask(input logic [LIMIT_W-1:0] rem);
      word_type m;
      m = '1;
      if (rem < LIMIT_W'(MAP_WORD_BITS)) begin
         m = ~({MAP_WORD_BITS{1'b1}} << rem[BIT_W-1:0]);
      end
      return m;
   endfunction

endpackage

// ----- design/bmalloc_ctrl.sv -----
`timescale 1ns / 1ps

module bmalloc_ctrl import bmalloc_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   input  stat_type stat,
   output logic     busy,
   output cmd_type  cmd
);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_DECODE = 4'd1;
   localparam logic [3:0] S_RDOUT  = 4'd2;
   localparam logic [3:0] S_IRD    = 4'd3;
   localparam logic [3:0] S_IEV    = 4'd4;
   localparam logic [3:0] S_BRD    = 4'd5;
   localparam logic [3:0] S_BEV    = 4'd6;
   localparam logic [3:0] S_PICK   = 4'd7;
   localparam logic [3:0] S_FINAL  = 4'd8;
   localparam logic [3:0] S_IMRD   = 4'd9;
   localparam logic [3:0] S_IMWR   = 4'd10;
   localparam logic [3:0] S_BMRD   = 4'd11;
   localparam logic [3:0] S_BMWR   = 4'd12;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   assign busy = (state_ff != S_IDLE);

   always_comb begin
      cmd      = '0;
      cmd.rd_sel = RS_REQ;
      cmd.map_wr = WR_NONE;
      cmd.emit   = EMIT_NONE;
      cmd.err    = ST_OK;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = S_DECODE;
            end
         end
         S_DECODE: begin
            unique case (stat.op)
               OP_LOAD_INODE, OP_LOAD_DATA: begin
                  cmd.map_wr = WR_LOAD;
                  state_in   = S_IDLE;
               end
               OP_READ_INODE, OP_READ_DATA: begin
                  cmd.rd_sel = RS_REQ;
                  state_in   = S_RDOUT;
               end
               OP_ALLOC: begin
                  priority if (stat.too_large) begin
                     cmd.emit = EMIT_ERR;
                     cmd.err  = ST_TOO_LARGE;
                     state_in = S_IDLE;
                  end else if (stat.inode_none) begin
                     cmd.emit = EMIT_ERR;
                     cmd.err  = ST_NO_INODE;
                     state_in = S_IDLE;
                  end else begin
                     cmd.scan_init = 1'b1;
                     state_in      = S_IRD;
                  end
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end
         S_RDOUT: begin
            cmd.emit = EMIT_READ;
            state_in = S_IDLE;
         end
         S_IRD: begin
            cmd.rd_sel = RS_SCAN;
            state_in   = S_IEV;
         end
         S_IEV: begin
            priority if (stat.ino_found) begin
               cmd.ino_take  = 1'b1;
               cmd.scan_init = 1'b1;
               if (stat.dlimit_zero) begin
                  cmd.emit = EMIT_ERR;
                  cmd.err  = ST_NO_BLOCKS;
                  state_in = S_IDLE;
               end else begin
                  state_in = S_BRD;
               end
            end else if (stat.ino_last) begin
               cmd.emit = EMIT_ERR;
               cmd.err  = ST_NO_INODE;
               state_in = S_IDLE;
            end else begin
               cmd.scan_next = 1'b1;
               state_in      = S_IRD;
            end
         end
         S_BRD: begin
            cmd.rd_sel = RS_SCAN;
            state_in   = S_BEV;
         end
         S_BEV: begin
            cmd.bword_load = 1'b1;
            state_in       = S_PICK;
         end
         S_PICK: begin
            priority if (stat.bfree_nz) begin
               cmd.pick = 1'b1;
               if (stat.pick_done) begin
                  state_in = S_FINAL;
               end
            end else if (stat.blk_last) begin
               cmd.emit = EMIT_ERR;
               cmd.err  = ST_NO_BLOCKS;
               state_in = S_IDLE;
            end else begin
               cmd.scan_next = 1'b1;
               state_in      = S_BRD;
            end
         end
         S_FINAL: begin
            if (stat.ovf) begin
               cmd.emit = EMIT_ERR;
               cmd.err  = ST_OVERFLOW;
               state_in = S_IDLE;
            end else begin
               state_in = S_IMRD;
            end
         end
         S_IMRD: begin
            cmd.rd_sel = RS_INODE;
            state_in   = S_IMWR;
         end
         S_IMWR: begin
            cmd.map_wr = WR_IMARK;
            state_in   = S_BMRD;
         end
         S_BMRD: begin
            cmd.rd_sel = RS_CHOSEN;
            state_in   = S_BMWR;
         end
         S_BMWR: begin
            cmd.map_wr = WR_BMARK;
            cmd.emit   = EMIT_BLOCK;
            if (stat.slot_last) begin
               state_in = S_IDLE;
            end else begin
               cmd.slot_next = 1'b1;
               state_in      = S_BMRD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- design/bmalloc_dp.sv -----
`timescale 1ns / 1ps

module bmalloc_dp import bmalloc_pkg::*; #(
   parameter int BLOCK_BYTES     = DEF_BLOCK_BYTES,
   parameter int MAX_FILE_BLOCKS = DEF_MAX_FILE_BLOCKS
) (
   input  logic              clock,
   input  logic              reset,
   input  req_type           req_payload,
   input  logic              csr_valid,
   input  logic [CSR_W-1:0]  csr_index,
   input  logic [31:0]       csr_wdata,
   input  cmd_type           cmd,
   output stat_type          stat,
   output logic              rsp_strobe,
   output rsp_type           rsp_payload
);

   localparam int SHIFT  = $clog2(BLOCK_BYTES);
   localparam int NEED_W = 33 - SHIFT;
   localparam int SLOT_W = $clog2(MAX_FILE_BLOCKS + 1);
   localparam int IDX_W  = (MAX_FILE_BLOCKS > 1) ? $clog2(MAX_FILE_BLOCKS) : 1;
   localparam logic [31:0] REM_MASK = 32'(BLOCK_BYTES - 1);

   logic [LIMIT_W-1:0] inode_total_ff;
   logic [LIMIT_W-1:0] data_total_ff;
   logic [31:0]        data_base_ff;
   req_type            req_ff;

   logic [WIDX_W-1:0]  scan_w_ff;
   logic [SLOT_W-1:0]  got_ff;
   logic [SLOT_W-1:0]  slot_ff;
   logic               ovf_ff;
   logic [ENTRY_W-1:0] ino_ff;
   word_type           free_ff;
   logic [ENTRY_W-1:0] chosen_ff [MAX_FILE_BLOCKS];

   word_type           imap_mem [MAP_WORDS];
   word_type           bmap_mem [MAP_WORDS];
   word_type           idata_ff;
   word_type           bdata_ff;

   logic               rsp_strobe_ff;
   rsp_type            rsp_payload_ff;
   rsp_type            rsp_payload_in;

   // Block count, rounded up and at least one.
   logic [NEED_W-1:0]  need_raw;
   logic [NEED_W-1:0]  need_eff;
   logic [SLOT_W-1:0]  need_s;

   logic [LIMIT_W-1:0] ilimit;
   logic [LIMIT_W-1:0] dlimit;
   logic [ENTRY_W-1:0] word_base;
   logic [LIMIT_W-1:0] irem;
   logic [LIMIT_W-1:0] drem;
   word_type           imask;
   word_type           ifree;
   logic [BIT_W-1:0]   pick_bit;
   logic [ENTRY_W-1:0] pick_idx;
   logic [32:0]        pick_sum;
   logic [ENTRY_W-1:0] cur_idx;

   logic [WIDX_W-1:0]  raddr;
   logic               imap_we;
   logic               bmap_we;
   logic [WIDX_W-1:0]  iwaddr;
   logic [WIDX_W-1:0]  bwaddr;
   word_type           iwdata;
   word_type           bwdata;

   assign need_raw = NEED_W'(req_ff.file_size_bytes >> SHIFT)
                     + NEED_W'(|(req_ff.file_size_bytes & REM_MASK));
   assign need_eff = (need_raw == '0) ? NEED_W'(1) : need_raw;
   assign need_s   = SLOT_W'(need_eff);

   assign ilimit = (inode_total_ff > LIMIT_W'(MAP_ENTRIES)) ? LIMIT_W'(MAP_ENTRIES)
                                                           : inode_total_ff;
   assign dlimit = (data_total_ff > LIMIT_W'(MAP_ENTRIES)) ? LIMIT_W'(MAP_ENTRIES)
                                                          : data_total_ff;

   // Entries left from the start of the current word up to the limit.
   assign word_base = {scan_w_ff, BIT_W'(0)};
   assign irem      = ilimit - LIMIT_W'(word_base);
   assign drem      = dlimit - LIMIT_W'(word_base);

   // Inode zero is never handed out.
   assign imask = low_mask(irem) & ((scan_w_ff == '0) ? ~word_type'(1) : '1);
   assign ifree = ~idata_ff & imask;

   assign pick_bit = lowest_one(free_ff);
   assign pick_idx = {scan_w_ff, pick_bit};
   assign pick_sum = {1'b0, data_base_ff} + 33'(pick_idx);
   assign cur_idx  = chosen_ff[slot_ff[IDX_W-1:0]];

   always_comb begin
      stat             = '0;
      stat.op          = req_ff.operation;
      stat.too_large   = (need_eff > NEED_W'(MAX_FILE_BLOCKS));
      stat.inode_none  = (ilimit <= LIMIT_W'(1));
      stat.ino_found   = (ifree != '0);
      stat.ino_last    = (irem <= LIMIT_W'(MAP_WORD_BITS));
      stat.dlimit_zero = (dlimit == '0);
      stat.bfree_nz    = (free_ff != '0);
      stat.blk_last    = (drem <= LIMIT_W'(MAP_WORD_BITS));
      stat.pick_done   = (SLOT_W'(got_ff + SLOT_W'(1)) == need_s);
      stat.ovf         = ovf_ff;
      stat.slot_last   = (SLOT_W'(slot_ff + SLOT_W'(1)) == need_s);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inode_total_ff <= LIMIT_W'(1);
         data_total_ff  <= '0;
         data_base_ff   <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_INODE_TOTAL: inode_total_ff <= csr_wdata[LIMIT_W-1:0];
            CSR_DATA_TOTAL:  data_total_ff  <= csr_wdata[LIMIT_W-1:0];
            CSR_DATA_BASE:   data_base_ff   <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_payload;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_w_ff <= '0;
         got_ff    <= '0;
         slot_ff   <= '0;
         ovf_ff    <= 1'b0;
      end else begin
         if (cmd.scan_init) begin
            scan_w_ff <= '0;
            got_ff    <= '0;
            slot_ff   <= '0;
            ovf_ff    <= 1'b0;
         end else begin
            if (cmd.scan_next) begin
               scan_w_ff <= scan_w_ff + WIDX_W'(1);
            end
            if (cmd.pick) begin
               got_ff <= got_ff + SLOT_W'(1);
               ovf_ff <= ovf_ff | pick_sum[32];
            end
            if (cmd.slot_next) begin
               slot_ff <= slot_ff + SLOT_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.ino_take) begin
         ino_ff <= {scan_w_ff, lowest_one(ifree)};
      end
      if (cmd.bword_load) begin
         free_ff <= ~bdata_ff & low_mask(drem);
      end else if (cmd.pick) begin
         free_ff <= free_ff & ~(word_type'(1) << pick_bit);
      end
      if (cmd.pick) begin
         chosen_ff[got_ff[IDX_W-1:0]] <= pick_idx;
      end
   end

   always_comb begin
      unique case (cmd.rd_sel)
         RS_REQ:    raddr = req_ff.word_index;
         RS_SCAN:   raddr = scan_w_ff;
         RS_INODE:  raddr = ino_ff[ENTRY_W-1:BIT_W];
         RS_CHOSEN: raddr = cur_idx[ENTRY_W-1:BIT_W];
      endcase
   end

   // Marks are read-modify-write: the word was read in the previous cycle.
   assign imap_we = ((cmd.map_wr == WR_LOAD) && (req_ff.operation == OP_LOAD_INODE))
                    || (cmd.map_wr == WR_IMARK);
   assign bmap_we = ((cmd.map_wr == WR_LOAD) && (req_ff.operation == OP_LOAD_DATA))
                    || (cmd.map_wr == WR_BMARK);
   assign iwaddr  = (cmd.map_wr == WR_IMARK) ? ino_ff[ENTRY_W-1:BIT_W]
                                              : req_ff.word_index;
   assign bwaddr  = (cmd.map_wr == WR_BMARK) ? cur_idx[ENTRY_W-1:BIT_W]
                                              : req_ff.word_index;
   assign iwdata  = (cmd.map_wr == WR_IMARK)
                    ? (idata_ff | (word_type'(1) << ino_ff[BIT_W-1:0]))
                    : word_type'(req_ff.word_value);
   assign bwdata  = (cmd.map_wr == WR_BMARK)
                    ? (bdata_ff | (word_type'(1) << cur_idx[BIT_W-1:0]))
                    : word_type'(req_ff.word_value);

   always_ff @(posedge clock) begin
      if (imap_we) begin
         imap_mem[iwaddr] <= iwdata;
      end
   end

   always_ff @(posedge clock) begin
      if (bmap_we) begin
         bmap_mem[bwaddr] <= bwdata;
      end
   end

   always_ff @(posedge clock) begin
      idata_ff <= imap_mem[raddr];
      bdata_ff <= bmap_mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= (cmd.emit != EMIT_NONE);
      end
   end

   always_comb begin
      rsp_payload_in = rsp_payload_ff;
      unique case (cmd.emit)
         EMIT_NONE: begin
         end
         EMIT_READ: begin
            rsp_payload_in            = '0;
            rsp_payload_in.status     = ST_OK;
            rsp_payload_in.read_value = (req_ff.operation == OP_READ_DATA)
                                        ? 32'(bdata_ff) : 32'(idata_ff);
            rsp_payload_in.last       = 1'b1;
         end
         EMIT_ERR: begin
            rsp_payload_in        = '0;
            rsp_payload_in.status = cmd.err;
            rsp_payload_in.last   = 1'b1;
         end
         EMIT_BLOCK: begin
            rsp_payload_in.status       = ST_OK;
            rsp_payload_in.inode_number = 16'(ino_ff) + 16'd1;
            rsp_payload_in.block_number = data_base_ff + 32'(cur_idx);
            rsp_payload_in.block_slot   = 4'(slot_ff);
            rsp_payload_in.read_value   = '0;
            rsp_payload_in.last         = stat.slot_last;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_payload = rsp_payload_ff;

   a_pick_has_free: assert property (@(posedge clock) disable iff (reset)
      cmd.pick |-> (free_ff != '0))
      else $error("block pick issued on an exhausted word");

   a_pick_within_need: assert property (@(posedge clock) disable iff (reset)
      cmd.pick |-> (got_ff < need_s))
      else $error("more blocks picked than the file needs");

   a_mark_after_read: assert property (@(posedge clock) disable iff (reset)
      (cmd.map_wr == WR_BMARK) |-> ($past(cmd.rd_sel) == RS_CHOSEN))
      else $error("block mark written without a fresh read of its word");

   a_no_commit_on_ovf: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit == EMIT_BLOCK) |-> !ovf_ff)
      else $error("blocks committed although a block number overflowed");

endmodule

// ----- design/bitmap_inode_and_block_allocator_core.sv -----
`timescale 1ns / 1ps
// Loads give no result; reads give one result.
// An allocate scans the inode map one map word at a time, then the block map word by word,
// picking the chosen blocks from each word, through the single read port of each map;
// it then marks the inode and each block by a read and a write, one result a block.
// One item is in work at a time; results come one cycle each and cannot be stalled.
// Synchronous reset returns control and configuration to their reset values; map contents are kept.

module bitmap_inode_and_block_allocator_core import bmalloc_pkg::*; #(
   parameter int BLOCK_BYTES     = DEF_BLOCK_BYTES,
   parameter int MAX_FILE_BLOCKS = DEF_MAX_FILE_BLOCKS
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  req_type          req_payload,
   output logic             rsp_strobe,
   output rsp_type          rsp_payload,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [CSR_W-1:0] csr_index,
   input  logic [31:0]      csr_wdata
);

   cmd_type  cmd;
   stat_type stat;

   assign csr_ready = 1'b1;

   bmalloc_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .busy  (busy),
      .cmd   (cmd)
   );

   bmalloc_dp #(
      .BLOCK_BYTES     (BLOCK_BYTES),
      .MAX_FILE_BLOCKS (MAX_FILE_BLOCKS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .csr_valid   (csr_valid),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .cmd         (cmd),
      .stat        (stat),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload)
   );

endmodule

// ----- tb/bitmap_inode_and_block_allocator_core_test.sv -----
`timescale 1ns / 1ps

module bitmap_inode_and_block_allocator_core_test;
   import bmalloc_pkg::*;

   localparam int BLOCK_BYTES     = DEF_BLOCK_BYTES;
   localparam int MAX_BLOCKS      = DEF_MAX_FILE_BLOCKS;
   localparam int SETTLE_CYCLES   = 16;
   localparam int CYCLE_LIMIT     = 5_000_000;
   localparam int SHOWN_MISMATCHES = 10;
   localparam int RANDOM_PHASES   = 5;
   localparam int PHASE_ITEMS     = 42;
   localparam int LOADED_WORDS    = 24;
   localparam int LOADED_ENTRIES  = LOADED_WORDS * MAP_WORD_BITS;

   // Operation codes the block must ignore.
   localparam logic [2:0] OP_UNUSED_LO = 3'd5;
   localparam logic [2:0] OP_UNUSED_HI = 3'd7;

   logic              clock = 1'b0;
   logic              reset;
   logic              start;
   logic              busy;
   req_type           req_payload;
   logic              rsp_strobe;
   rsp_type           rsp_payload;
   logic              csr_valid;
   logic              csr_ready;
   logic [CSR_W-1:0]  csr_index;
   logic [31:0]       csr_wdata;

   // Shadow copy of the two bitmaps and of the allocation limits.
   word_type    inode_bits [MAP_WORDS];
   word_type    block_bits [MAP_WORDS];
   logic [15:0] inode_limit;
   logic [15:0] block_count;
   logic [31:0] region_base;

   rsp_type owed_rsp [$];
   int      mismatch_count = 0;
   int      cycle_count = 0;
   bit      steady_feed = 1'b0;

   bitmap_inode_and_block_allocator_core dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   function automatic req_type make_item(input logic [2:0] op, input logic [9:0] index,
                                         input logic [31:0] value, input logic [31:0] size);
      req_type item;
      item.operation       = op;
      item.word_index      = index;
      item.word_value      = value;
      item.file_size_bytes = size;
      return item;
   endfunction

   function automatic void owe_error(input logic [2:0] status);
      rsp_type r;
      r        = '0;
      r.status = status;
      r.last   = 1'b1;
      owed_rsp.push_back(r);
   endfunction

   function automatic void predict_allocation(input logic [31:0] size);
      logic [32:0] need_wide;
      int          need;
      int          ilimit;
      int          dlimit;
      int          ino;
      int          got;
      int          chosen [MAX_BLOCKS];
      bit          wraps;
      rsp_type     r;
      need_wide = ({1'b0, size} + 33'(BLOCK_BYTES - 1)) / 33'(BLOCK_BYTES);
      if (need_wide == 0) need_wide = 1;
      if (need_wide > 33'(MAX_BLOCKS)) begin
         owe_error(ST_TOO_LARGE);
         return;
      end
      need = int'(need_wide);

      // Inode 0 is reserved, so a zero index means nothing was found.
      ilimit = (int'(inode_limit) < MAP_ENTRIES) ? int'(inode_limit) : MAP_ENTRIES;
      ino = 0;
      for (int i = 1; i < ilimit && ino == 0; i++) begin
         if (!inode_bits[i / MAP_WORD_BITS][i % MAP_WORD_BITS]) ino = i;
      end
      if (ino == 0) begin
         owe_error(ST_NO_INODE);
         return;
      end

      dlimit = (int'(block_count) < MAP_ENTRIES) ? int'(block_count) : MAP_ENTRIES;
      got = 0;
      for (int i = 0; i < dlimit && got < need; i++) begin
         if (!block_bits[i / MAP_WORD_BITS][i % MAP_WORD_BITS]) begin
            chosen[got] = i;
            got = got + 1;
         end
      end
      if (got < need) begin
         owe_error(ST_NO_BLOCKS);
         return;
      end

      wraps = 1'b0;
      for (int k = 0; k < need; k++) begin
         if ({1'b0, region_base} + 33'(chosen[k]) > 33'h0_FFFF_FFFF) wraps = 1'b1;
      end
      if (wraps) begin
         owe_error(ST_OVERFLOW);
         return;
      end

      for (int k = 0; k < need; k++) begin
         block_bits[chosen[k] / MAP_WORD_BITS][chosen[k] % MAP_WORD_BITS] = 1'b1;
         r              = '0;
         r.status       = ST_OK;
         r.inode_number = 16'(ino + 1);
         r.block_number = region_base + 32'(chosen[k]);
         r.block_slot   = 4'(k);
         r.last         = (k == need - 1);
         owed_rsp.push_back(r);
      end
      inode_bits[ino / MAP_WORD_BITS][ino % MAP_WORD_BITS] = 1'b1;
   endfunction

   function automatic void predict_bitmap_op(input req_type item);
      rsp_type r;
      r        = '0;
      r.status = ST_OK;
      r.last   = 1'b1;
      case (item.operation)
         OP_LOAD_INODE: inode_bits[item.word_index] = item.word_value;
         OP_LOAD_DATA:  block_bits[item.word_index] = item.word_value;
         OP_READ_INODE: begin
            r.read_value = inode_bits[item.word_index];
            owed_rsp.push_back(r);
         end
         OP_READ_DATA: begin
            r.read_value = block_bits[item.word_index];
            owed_rsp.push_back(r);
         end
         OP_ALLOC: predict_allocation(item.file_size_bytes);
         default: ;
      endcase
   endfunction

   function automatic int pick_gap();
      int roll;
      if (steady_feed) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // One request beat: start stays up until the block takes it.
   task automatic send_item(input req_type item);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start       <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (busy);
      predict_bitmap_op(item);
   endtask

   // Loads and ignored codes give no result, so the block may still be
   // working after the last owed result; give it time to go idle.
   task automatic drain_results();
      start <= 1'b0;
      while (owed_rsp.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic set_limits(input logic [15:0] inodes, input logic [15:0] blocks,
                             input logic [31:0] base);
      logic [CSR_W-1:0] reg_at [3] = '{CSR_INODE_TOTAL, CSR_DATA_TOTAL, CSR_DATA_BASE};
      logic [31:0]      value [3];
      // Upper bits of the 16-bit counts are junk the block must drop.
      value[0] = {16'($urandom), inodes};
      value[1] = {16'($urandom), blocks};
      value[2] = base;
      for (int k = 0; k < 3; k++) begin
         csr_valid <= 1'b1;
         csr_index <= reg_at[k];
         csr_wdata <= value[k];
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid   <= 1'b0;
      inode_limit = inodes;
      block_count = blocks;
      region_base = base;
   endtask

   task automatic report_mismatch(input string what, input rsp_type want, input rsp_type got);
      mismatch_count++;
      if (mismatch_count <= SHOWN_MISMATCHES) begin
         $display("%0t %s: status %0d/%0d inode %0d/%0d block %h/%h", $realtime, what,
                  want.status, got.status, want.inode_number, got.inode_number,
                  want.block_number, got.block_number);
         $display("   slot %0d/%0d read %h/%h last %0d/%0d", want.block_slot,
                  got.block_slot, want.read_value, got.read_value, want.last, got.last);
      end
   endtask

   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (owed_rsp.size() == 0) begin
            report_mismatch("result with nothing owed (exp/got)", '0, rsp_payload);
         end else begin
            want = owed_rsp.pop_front();
            if (want.status !== rsp_payload.status ||
                want.inode_number !== rsp_payload.inode_number ||
                want.block_number !== rsp_payload.block_number ||
                want.block_slot !== rsp_payload.block_slot ||
                want.read_value !== rsp_payload.read_value ||
                want.last !== rsp_payload.last) begin
               report_mismatch("result mismatch (exp/got)", want, rsp_payload);
            end
         end
      end
   end

   // The maps come out of reset undefined, so every word the tests reach gets a
   // known value first; searches and reads stay inside these words.
   task automatic load_all_words();
      steady_feed = 1'b1;
      for (int w = 0; w < LOADED_WORDS; w++) begin
         send_item(make_item(OP_LOAD_INODE, 10'(w), '0, '0));
         send_item(make_item(OP_LOAD_DATA, 10'(w), '0, '0));
      end
      steady_feed = 1'b0;
      drain_results();
   endtask

   task automatic test_error_codes();
      // Reset limits leave no inode to search and no data blocks.
      send_item(make_item(OP_ALLOC, '0, '0, 32'd0));
      send_item(make_item(OP_ALLOC, '1, '1, 32'hFFFF_FFFF));
      send_item(make_item(OP_READ_INODE, 10'd0, '0, '0));
      send_item(make_item(OP_LOAD_DATA, 10'd1023, 32'hA5C3_0F96, '0));
      send_item(make_item(OP_READ_DATA, 10'd1023, '1, '0));
      send_item(make_item(OP_UNUSED_LO, 10'd0, '1, 32'd4096));
      send_item(make_item(OP_UNUSED_HI, '1, '1, '1));
      drain_results();
      set_limits(16'd64, 16'd0, 32'd0);
      send_item(make_item(OP_ALLOC, '0, '0, 32'd1));
   endtask

   task automatic test_first_fit();
      drain_results();
      set_limits(16'd40, 16'd40, 32'd100);
      send_item(make_item(OP_ALLOC, '0, '0, 32'd4096));
      send_item(make_item(OP_ALLOC, '0, '0, 32'd4097));
      send_item(make_item(OP_ALLOC, '0, '0, 32'(MAX_BLOCKS * BLOCK_BYTES)));
      send_item(make_item(OP_ALLOC, '0, '0, 32'(MAX_BLOCKS * BLOCK_BYTES + 1)));
      send_item(make_item(OP_READ_DATA, 10'd0, '0, '0));
      send_item(make_item(OP_READ_INODE, 10'd0, '0, '0));
      // Every searchable inode taken.
      send_item(make_item(OP_LOAD_INODE, 10'd0, 32'hFFFF_FFFF, '0));
      send_item(make_item(OP_LOAD_INODE, 10'd1, 32'h0000_00FF, '0));
      send_item(make_item(OP_ALLOC, '0, '0, 32'd1));
      // Inodes free again, but only eight data blocks left.
      send_item(make_item(OP_LOAD_INODE, 10'd1, 32'h0, '0));
      send_item(make_item(OP_LOAD_DATA, 10'd0, 32'hFFFF_FFFF, '0));
      send_item(make_item(OP_ALLOC, '0, '0, 32'(MAX_BLOCKS * BLOCK_BYTES)));
   endtask

   task automatic test_block_number_edges();
      drain_results();
      set_limits(16'hFFFF, 16'hFFFF, 32'hFFFF_FFF8);
      send_item(make_item(OP_LOAD_DATA, 10'd0, 32'h0, '0));
      send_item(make_item(OP_ALLOC, '0, '0, 32'd4096));
      send_item(make_item(OP_ALLOC, '0, '0, 32'(MAX_BLOCKS * BLOCK_BYTES)));
      drain_results();
      set_limits(16'd32768, 16'd32768, 32'hFFFF_FFFF);
      send_item(make_item(OP_ALLOC, '0, '0, 32'd1));
      send_item(make_item(OP_LOAD_DATA, 10'd0, 32'h0, '0));
      send_item(make_item(OP_ALLOC, '0, '0, 32'd0));
   endtask

   task automatic test_random_traffic();
      int          counted;
      int          hold_point;
      int          roll;
      logic [15:0] inodes;
      logic [15:0] blocks;
      logic [31:0] base;
      req_type     item;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         roll = $urandom_range(0, 99);
         if (roll < 8) inodes = 16'd1;
         else if (roll < 16) inodes = 16'd2;
         else if (roll < 24) inodes = 16'd33;
         else if (roll < 36) inodes = 16'(LOADED_ENTRIES);
         else inodes = 16'($urandom_range(3, LOADED_ENTRIES));
         roll = $urandom_range(0, 99);
         if (roll < 6) blocks = 16'd0;
         else if (roll < 16) blocks = 16'(LOADED_ENTRIES);
         else blocks = 16'($urandom_range(1, LOADED_ENTRIES));
         roll = $urandom_range(0, 99);
         if (roll < 20) base = 32'd0;
         else if (roll < 40) base = 32'hFFFF_FFFF - 32'($urandom_range(0, 800));
         else base = $urandom;

         drain_results();
         set_limits(inodes, blocks, base);
         steady_feed = ($urandom_range(0, 3) == 0);
         hold_point  = $urandom_range(10, 40);
         counted     = 0;
         while (counted < PHASE_ITEMS) begin
            item = make_item(OP_ALLOC, 10'($urandom), $urandom, $urandom);
            roll = $urandom_range(0, 99);
            if (roll < 40) item.operation = OP_ALLOC;
            else if (roll < 52) item.operation = OP_LOAD_INODE;
            else if (roll < 70) item.operation = OP_LOAD_DATA;
            else if (roll < 80) item.operation = OP_READ_INODE;
            else if (roll < 94) item.operation = OP_READ_DATA;
            else item.operation = 3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));

            // Only words loaded at the start are addressed.
            item.word_index = 10'($urandom_range(0, LOADED_WORDS - 1));

            roll = $urandom_range(0, 99);
            if (roll < 25) item.word_value = '0;
            else if (roll < 40) item.word_value = '1;
            else if (roll < 70) item.word_value = $urandom & $urandom;

            roll = $urandom_range(0, 99);
            if (roll < 50) begin
               item.file_size_bytes = $urandom_range(0, MAX_BLOCKS * BLOCK_BYTES);
            end else if (roll < 70) begin
               item.file_size_bytes = 32'($urandom_range(0, MAX_BLOCKS + 1) * BLOCK_BYTES)
                                      + 32'($urandom_range(0, 2)) - 32'd1;
            end else if (roll < 85) begin
               item.file_size_bytes = $urandom_range(0, 100);
            end

            send_item(item);
            if (item.operation <= OP_ALLOC) begin
               counted++;
               if (counted == hold_point) drain_results();
            end
         end
      end
      steady_feed = 1'b0;
   endtask

   initial begin
      reset       = 1'b1;
      start       = 1'b0;
      req_payload = '0;
      csr_valid   = 1'b0;
      csr_index   = CSR_INODE_TOTAL;
      csr_wdata   = '0;
      inode_limit = 16'd1;
      block_count = 16'd0;
      region_base = 32'd0;
      for (int w = 0; w < MAP_WORDS; w++) begin
         inode_bits[w] = '0;
         block_bits[w] = '0;
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      load_all_words();
      test_error_codes();
      test_first_fit();
      test_block_number_edges();
      test_random_traffic();
      drain_results();

      if (mismatch_count == 0 && owed_rsp.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
